// File: hdl/f2d_pkg.sv
// f2d_pkg: widths, constants and power tables for the float to decimal converter
// no dependencies; used by the channel interfaces and the top level

package f2d_pkg;

    localparam int FW        = 32;     // float bit pattern
    localparam int MW        = 24;     // significand with hidden bit
    localparam int QW        = 25;     // quotient bits out of the divider
    localparam int AW        = 107;    // dividend and divisor width
    localparam int P5C       = 28;     // chunk of a power of five
    localparam int P5W       = 3 * P5C;
    localparam int P10C      = 25;     // chunk of a power of ten
    localparam int P10W      = 77;
    localparam int J_MAX     = 35;     // highest power of five needed
    localparam int K_MAX     = 23;     // highest power of ten needed
    localparam int MANT_W    = 96;
    localparam int LOW_W     = 64;
    localparam int HIGH_W    = 32;
    localparam int SCALE_W   = 5;
    localparam int REDUCE_STAGES = 9;  // enough to take any 7 digit value to zero
    localparam int MAX_SCALE_DEF = 28;

    localparam logic [30:0]    MAG_LIMIT = 31'h6F800000;
    localparam logic [MW-1:0]  TEN7      = 24'd10000000;
    localparam logic [MW-1:0]  TEN6      = 24'd1000000;
    localparam logic [31:0]    RECIP10   = 32'hCCCCCCCD;  // ceil(2^35 / 10)
    localparam int             RECIP_SH  = 35;
    localparam int             LOG10_2_Q18 = 78913;        // log10(2) * 2^18

    typedef logic [P5W-1:0]  t_pow5_tab  [0:J_MAX];
    typedef logic [P10W-1:0] t_pow10_tab [0:K_MAX];

    function automatic t_pow5_tab mk_pow5();
        t_pow5_tab r;
        r[0] = P5W'(1);
        for (int i = 1; i <= J_MAX; i++) begin
            r[i] = r[i-1] * P5W'(5);
        end
        return r;
    endfunction

    function automatic t_pow10_tab mk_pow10();
        t_pow10_tab r;
        r[0] = P10W'(1);
        for (int i = 1; i <= K_MAX; i++) begin
            r[i] = r[i-1] * P10W'(10);
        end
        return r;
    endfunction

    localparam t_pow5_tab  POW5  = mk_pow5();
    localparam t_pow10_tab POW10 = mk_pow10();

endpackage

// File: hdl/f2d_if.sv
// f2d_in_if and f2d_out_if: valid/ready channels of the converter
// depends on f2d_pkg for the payload widths

interface f2d_in_if;
    logic                    valid;
    logic                    ready;
    logic [f2d_pkg::FW-1:0]  float_bits;

    modport source (output valid, output float_bits, input ready);
    modport sink   (input valid, input float_bits, output ready);
endinterface

interface f2d_out_if;
    logic                         valid;
    logic                         ready;
    logic [f2d_pkg::LOW_W-1:0]    mantissa_low;
    logic [f2d_pkg::HIGH_W-1:0]   mantissa_high;
    logic [f2d_pkg::SCALE_W-1:0]  scale;
    logic                         negative;
    logic                         status;

    modport source (output valid, output mantissa_low, output mantissa_high,
                    output scale, output negative, output status, input ready);
    modport sink   (input valid, input mantissa_low, input mantissa_high,
                    input scale, input negative, input status, output ready);
endinterface

// File: hdl/float_to_decimal96_convert.sv
// float_to_decimal96_convert: single precision float to 96-bit decimal, pipelined
// depends on f2d_pkg and the channel interfaces in f2d_if.sv
//
// Usage:
//   i_in  carries one float bit pattern per beat (valid/ready).
//   o_out carries one decimal result per beat: 96-bit mantissa, scale 0 to
//   MAX_SCALE, sign and status (1 = NaN, infinity, out of range; result zeroed).
//   Every input beat gives exactly one output beat, in order.
// Timing:
//   44 pipeline stages: decode, 3 for the power-of-five multiply and shift,
//   25 restoring divider stages (one quotient bit each), 3 rounding stages,
//   2 for the power-of-ten multiply, 9 scale reduction stages and the output
//   register. A new beat is taken every cycle while the output is not stalled;
//   the divider chain sets most of the latency.
// Reset:
//   i_rst_n low at a clock edge empties the pipeline; no result is shown after.
// Stall:
//   when o_out holds a result that is not taken, the whole pipeline holds and
//   i_in.ready drops; nothing is lost or repeated. Bubbles keep flowing while
//   the output register is empty.

module float_to_decimal96_convert #(
    parameter int MAX_SCALE = f2d_pkg::MAX_SCALE_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    f2d_in_if.sink       i_in,
    f2d_out_if.source    o_out
);

    localparam int AW  = f2d_pkg::AW;
    localparam int QW  = f2d_pkg::QW;
    localparam int MW  = f2d_pkg::MW;
    localparam int RS  = f2d_pkg::REDUCE_STAGES;
    localparam int NS  = 4 + QW + 5 + RS + 1;
    localparam logic signed [7:0] MAX_S = 8'(MAX_SCALE);

    typedef struct packed {
        logic neg;
        logic err;
        logic zero;
    } t_side;

    typedef struct packed {
        t_side              side;
        logic [MW-1:0]      m;
        logic signed [9:0]  e2;
        logic signed [6:0]  d0;
        logic               divp;
        logic [5:0]         j;
        logic signed [9:0]  t;
        logic [4:0]         kdiv;
    } t_dec;

    typedef struct packed {
        t_side                        side;
        logic [MW-1:0]                m;
        logic signed [9:0]            e2;
        logic signed [6:0]            d0;
        logic                         divp;
        logic signed [9:0]            t;
        logic [4:0]                   kdiv;
        logic [2:0][MW+f2d_pkg::P5C-1:0] pp;
    } t_mul;

    typedef struct packed {
        t_side              side;
        logic [MW-1:0]      m;
        logic signed [9:0]  e2;
        logic signed [6:0]  d0;
        logic               divp;
        logic signed [9:0]  t;
        logic [4:0]         kdiv;
        logic [AW-1:0]      p;
    } t_sum;

    typedef struct packed {
        t_side              side;
        logic signed [6:0]  d0;
        logic [AW-1:0]      rem;
        logic [AW-1:0]      dvs;
        logic [QW-1:0]      quo;
    } t_dv;

    typedef struct packed {
        t_side              side;
        logic signed [6:0]  d0;
        logic [QW-1:0]      quo;
        logic               rnz;
        logic               gt;
        logic               eq;
        logic [21:0]        qd;
    } t_flg;

    typedef struct packed {
        t_side              side;
        logic signed [7:0]  d;
        logic [MW-1:0]      q;
        logic               up;
    } t_sel;

    typedef struct packed {
        t_side              side;
        logic [MW-1:0]      q;
        logic signed [7:0]  scale;
    } t_rnd;

    typedef struct packed {
        t_side                            side;
        logic signed [7:0]                scale;
        logic [2:0][MW+f2d_pkg::P10C-1:0] pp;
    } t_pm;

    typedef struct packed {
        t_side                        side;
        logic [f2d_pkg::MANT_W-1:0]   mant;
        logic [f2d_pkg::SCALE_W-1:0]  scale;
        logic [5:0]                   need;
    } t_rd;

    typedef struct packed {
        logic [f2d_pkg::LOW_W-1:0]    lo;
        logic [f2d_pkg::HIGH_W-1:0]   hi;
        logic [f2d_pkg::SCALE_W-1:0]  scale;
        logic                         neg;
        logic                         status;
    } t_out;

    logic          w_en;
    logic [NS-1:0] r_vld;

    t_dec r_dec, n_dec;
    t_mul r_mul, n_mul;
    t_sum r_sum, n_sum;
    t_dv  r_dv [0:QW];
    t_dv  n_dv [0:QW];
    t_flg r_flg, n_flg;
    t_sel r_sel, n_sel;
    t_rnd r_rnd, n_rnd;
    t_pm  r_pm, n_pm;
    t_rd  r_rd [0:RS];
    t_rd  n_rd [0:RS];
    t_out r_out, n_out;

    assign w_en       = !r_vld[NS-1] || o_out.ready;
    assign i_in.ready = w_en;

    // decode and first decimal exponent estimate
    logic [30:0]        w_mag;
    logic [7:0]         w_be;
    logic signed [9:0]  w_n;
    logic signed [27:0] w_lp;
    logic signed [7:0]  w_k0;
    logic signed [7:0]  w_negk;
    logic               w_lo_err;

    always_comb begin
        w_mag  = i_in.float_bits[30:0];
        w_be   = w_mag[30:23];
        n_dec.side.neg  = i_in.float_bits[31];
        n_dec.m  = {1'b1, w_mag[22:0]};
        n_dec.e2 = $signed({2'b00, w_be}) - 10'sd150;
        w_n      = n_dec.e2 + 10'sd23;
        w_lp     = 28'(w_n) * 28'(f2d_pkg::LOG10_2_Q18);
        n_dec.d0 = 7'(w_lp >>> 18);
        w_k0     = 8'(n_dec.d0) - 8'sd6;
        w_negk   = -w_k0;
        n_dec.divp = w_k0 > 8'sd0;
        w_lo_err = (w_be == 8'd0) || (n_dec.d0 < -7'sd29);
        n_dec.side.zero = (w_mag == 31'd0);
        n_dec.side.err  = (w_mag > f2d_pkg::MAG_LIMIT) || (!n_dec.side.zero && w_lo_err);
        if (n_dec.divp) begin
            n_dec.j = 6'd0;
        end else if (w_negk > 8'sd35) begin
            n_dec.j = 6'(f2d_pkg::J_MAX);
        end else begin
            n_dec.j = w_negk[5:0];
        end
        n_dec.t = n_dec.e2 + $signed({4'b0000, n_dec.j});
        if (!n_dec.divp) begin
            n_dec.kdiv = 5'd0;
        end else if (w_k0 > 8'(f2d_pkg::K_MAX)) begin
            n_dec.kdiv = 5'(f2d_pkg::K_MAX);
        end else begin
            n_dec.kdiv = w_k0[4:0];
        end
    end

    // significand times a power of five, in three partial products
    always_comb begin
        n_mul.side = r_dec.side;
        n_mul.m    = r_dec.m;
        n_mul.e2   = r_dec.e2;
        n_mul.d0   = r_dec.d0;
        n_mul.divp = r_dec.divp;
        n_mul.t    = r_dec.t;
        n_mul.kdiv = r_dec.kdiv;
        for (int c = 0; c < 3; c++) begin
            n_mul.pp[c] = (MW+f2d_pkg::P5C)'(r_dec.m) *
                (MW+f2d_pkg::P5C)'(f2d_pkg::POW5[r_dec.j][c*f2d_pkg::P5C +: f2d_pkg::P5C]);
        end
    end

    always_comb begin
        n_sum.side = r_mul.side;
        n_sum.m    = r_mul.m;
        n_sum.e2   = r_mul.e2;
        n_sum.d0   = r_mul.d0;
        n_sum.divp = r_mul.divp;
        n_sum.t    = r_mul.t;
        n_sum.kdiv = r_mul.kdiv;
        n_sum.p    = AW'(r_mul.pp[0]) + (AW'(r_mul.pp[1]) << f2d_pkg::P5C)
                   + (AW'(r_mul.pp[2]) << (2*f2d_pkg::P5C));
    end

    // dividend and divisor: integer over a power of ten, or a dyadic fraction
    logic [AW-1:0]     w_base;
    logic [6:0]        w_sh;
    logic signed [9:0] w_negt;

    // restoring divider, one quotient bit per stage, msb first
    logic [AW+QW-1:0] w_trial [0:QW-1];
    logic             w_ge    [0:QW-1];

    always_comb begin
        w_negt = -r_sum.t;
        w_base = r_sum.divp ? AW'(r_sum.m) : r_sum.p;
        if (r_sum.divp) begin
            w_sh = r_sum.e2[6:0];
        end else if (r_sum.t >= 10'sd0) begin
            w_sh = r_sum.t[6:0];
        end else begin
            w_sh = 7'd0;
        end
        n_dv[0].side = r_sum.side;
        n_dv[0].d0   = r_sum.d0;
        n_dv[0].rem  = w_base << w_sh;
        n_dv[0].quo  = '0;
        if (r_sum.divp) begin
            n_dv[0].dvs = AW'(f2d_pkg::POW10[r_sum.kdiv]);
        end else if (r_sum.t < 10'sd0) begin
            n_dv[0].dvs = AW'(1) << w_negt;
        end else begin
            n_dv[0].dvs = AW'(1);
        end
        for (int g = 0; g < QW; g++) begin
            w_trial[g] = (AW+QW)'(r_dv[g].dvs) << (QW-1-g);
            w_ge[g]    = (AW+QW)'(r_dv[g].rem) >= w_trial[g];
            n_dv[g+1]  = r_dv[g];
            if (w_ge[g]) begin
                n_dv[g+1].rem = r_dv[g].rem - w_trial[g][AW-1:0];
            end
            n_dv[g+1].quo[QW-1-g] = w_ge[g];
        end
    end

    // fraction flags and quotient over ten
    logic [56:0] w_qm;

    always_comb begin
        n_flg.side = r_dv[QW].side;
        n_flg.d0   = r_dv[QW].d0;
        n_flg.quo  = r_dv[QW].quo;
        n_flg.rnz  = |r_dv[QW].rem;
        n_flg.gt   = {r_dv[QW].rem, 1'b0} > {1'b0, r_dv[QW].dvs};
        n_flg.eq   = {r_dv[QW].rem, 1'b0} == {1'b0, r_dv[QW].dvs};
        w_qm       = 57'(r_dv[QW].quo) * 57'(f2d_pkg::RECIP10);
        n_flg.qd   = 22'(w_qm >> f2d_pkg::RECIP_SH);
    end

    // pick seven digits and the round-up decision, ties to even
    logic [QW-1:0] w_dq;
    logic [3:0]    w_dig;
    logic          w_big;

    always_comb begin
        w_dq  = r_flg.quo - ((QW'(r_flg.qd) << 3) + (QW'(r_flg.qd) << 1));
        w_dig = w_dq[3:0];
        w_big = r_flg.quo >= QW'(f2d_pkg::TEN7);
        n_sel.side = r_flg.side;
        if (w_big) begin
            n_sel.q  = MW'(r_flg.qd);
            n_sel.d  = 8'(r_flg.d0) + 8'sd1;
            n_sel.up = (w_dig > 4'd5) || (w_dig == 4'd5 && (r_flg.rnz || r_flg.qd[0]));
        end else begin
            n_sel.q  = r_flg.quo[MW-1:0];
            n_sel.d  = 8'(r_flg.d0);
            n_sel.up = r_flg.gt || (r_flg.eq && r_flg.quo[0]);
        end
        // magnitude below 1e-28
        if (n_sel.d < -8'sd28) begin
            n_sel.side.err = 1'b1;
        end
    end

    logic [MW:0] w_qr;

    always_comb begin
        w_qr       = (MW+1)'(r_sel.q) + (MW+1)'(r_sel.up);
        n_rnd.side = r_sel.side;
        if (w_qr == (MW+1)'(f2d_pkg::TEN7)) begin
            n_rnd.q     = f2d_pkg::TEN6;
            n_rnd.scale = 8'sd6 - (r_sel.d + 8'sd1);
        end else begin
            n_rnd.q     = w_qr[MW-1:0];
            n_rnd.scale = 8'sd6 - r_sel.d;
        end
    end

    // negative scale: mantissa times a power of ten
    logic signed [7:0] w_nsc;
    logic [4:0]        w_pidx;

    always_comb begin
        w_nsc = -r_rnd.scale;
        if (r_rnd.scale >= 8'sd0) begin
            w_pidx = 5'd0;
        end else if (w_nsc > 8'sd22) begin
            w_pidx = 5'd22;
        end else begin
            w_pidx = w_nsc[4:0];
        end
        n_pm.side  = r_rnd.side;
        n_pm.scale = r_rnd.scale;
        for (int c = 0; c < 3; c++) begin
            n_pm.pp[c] = (MW+f2d_pkg::P10C)'(r_rnd.q) *
                (MW+f2d_pkg::P10C)'(f2d_pkg::POW10[w_pidx][c*f2d_pkg::P10C +: f2d_pkg::P10C]);
        end
    end

    // scale reduction, one divide-by-ten with ties to even per stage
    logic [MW-1:0] w_rn  [0:RS-1];
    logic [55:0]   w_rw  [0:RS-1];
    logic [20:0]   w_rq  [0:RS-1];
    logic [MW-1:0] w_rr  [0:RS-1];

    always_comb begin
        n_rd[0].side = r_pm.side;
        n_rd[0].mant = f2d_pkg::MANT_W'(r_pm.pp[0])
                     + (f2d_pkg::MANT_W'(r_pm.pp[1]) << f2d_pkg::P10C)
                     + (f2d_pkg::MANT_W'(r_pm.pp[2]) << (2*f2d_pkg::P10C));
        if (r_pm.scale < 8'sd0) begin
            n_rd[0].scale = '0;
            n_rd[0].need  = '0;
        end else if (r_pm.scale > MAX_S) begin
            n_rd[0].scale = f2d_pkg::SCALE_W'(MAX_SCALE);
            n_rd[0].need  = 6'(r_pm.scale - MAX_S);
        end else begin
            n_rd[0].scale = r_pm.scale[f2d_pkg::SCALE_W-1:0];
            n_rd[0].need  = '0;
        end
        for (int g = 0; g < RS; g++) begin
            w_rn[g]   = r_rd[g].mant[MW-1:0];
            w_rw[g]   = 56'(w_rn[g]) * 56'(f2d_pkg::RECIP10);
            w_rq[g]   = 21'(w_rw[g] >> f2d_pkg::RECIP_SH);
            w_rr[g]   = w_rn[g] - ((MW'(w_rq[g]) << 3) + (MW'(w_rq[g]) << 1));
            n_rd[g+1] = r_rd[g];
            if (r_rd[g].need > 6'(g)) begin
                if (w_rr[g] > MW'(5) || (w_rr[g] == MW'(5) && w_rq[g][0])) begin
                    n_rd[g+1].mant = f2d_pkg::MANT_W'(w_rq[g]) + f2d_pkg::MANT_W'(1);
                end else begin
                    n_rd[g+1].mant = f2d_pkg::MANT_W'(w_rq[g]);
                end
            end
        end
    end

    always_comb begin
        n_out = '0;
        if (r_rd[RS].side.zero || (!r_rd[RS].side.err && r_rd[RS].mant == '0)) begin
            n_out = '0;
        end else if (r_rd[RS].side.err) begin
            n_out.status = 1'b1;
        end else begin
            n_out.lo    = r_rd[RS].mant[f2d_pkg::LOW_W-1:0];
            n_out.hi    = r_rd[RS].mant[f2d_pkg::MANT_W-1:f2d_pkg::LOW_W];
            n_out.scale = r_rd[RS].scale;
            n_out.neg   = r_rd[RS].side.neg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NS-2:0], i_in.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dec <= n_dec;
            r_mul <= n_mul;
            r_sum <= n_sum;
            r_dv  <= n_dv;
            r_flg <= n_flg;
            r_sel <= n_sel;
            r_rnd <= n_rnd;
            r_pm  <= n_pm;
            r_rd  <= n_rd;
            r_out <= n_out;
        end
    end

    assign o_out.valid         = r_vld[NS-1];
    assign o_out.mantissa_low  = r_out.lo;
    assign o_out.mantissa_high = r_out.hi;
    assign o_out.scale         = r_out.scale;
    assign o_out.negative      = r_out.neg;
    assign o_out.status        = r_out.status;

    a_err_zeroed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.status |->
            (o_out.mantissa_low == '0 && o_out.mantissa_high == '0 &&
             o_out.scale == '0 && !o_out.negative))
        else $error("error beat carries a nonzero result");

    a_scale_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> o_out.scale <= f2d_pkg::SCALE_W'(MAX_SCALE))
        else $error("scale above limit");

    a_frac_digits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.status && o_out.scale != '0 |->
            (o_out.mantissa_high == '0 && o_out.mantissa_low < 64'd10000000))
        else $error("fractional result wider than seven digits");

    a_neg_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.negative |->
            (o_out.mantissa_low != '0 || o_out.mantissa_high != '0))
        else $error("negative flag on a zero result");

endmodule

// File: dv/float_to_decimal96_convert_test.sv
// float_to_decimal96_convert_test: checks the float to decimal converter beat by beat
// against an exact big-integer predictor; depends on f2d_pkg, f2d_if.sv and the rtl top

module float_to_decimal96_convert_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_SCALE = f2d_pkg::MAX_SCALE_DEF;
    localparam int LATENCY   = 44;
    localparam int WD_LIMIT  = 20000;

    typedef struct packed {
        logic [f2d_pkg::LOW_W-1:0]   mant_lo;
        logic [f2d_pkg::HIGH_W-1:0]  mant_hi;
        logic [f2d_pkg::SCALE_W-1:0] scale;
        logic                        neg;
        logic                        status;
    } t_dec_res;

    typedef struct {
        logic [f2d_pkg::FW-1:0] bits;
        logic                   has_exp;
        t_dec_res               exp_res;
    } t_stim_row;

    logic i_clk;
    logic i_rst_n;

    f2d_in_if  in_ch();
    f2d_out_if out_ch();

    float_to_decimal96_convert #(.MAX_SCALE(MAX_SCALE)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    t_dec_res pending_dec[$];
    int   mismatches;
    int   send_idle_pct;
    int   recv_idle_pct;
    bit   hold_recv;
    bit   stim_done;
    int   quiet_cycles;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // exact conversion: value = big * 10^e, round to 7 digits, then fit the scale
    function automatic t_dec_res convert_float(logic [f2d_pkg::FW-1:0] fb);
        t_dec_res     r;
        logic [383:0] big;
        logic [30:0] mag;
        logic [23:0] m;
        logic [3:0]  last;
        logic [95:0] n96;
        logic [99:0] wide;
        logic [3:0]  rem;
        logic [31:0] q;
        bit          sticky;
        int          e2, e, sc;
        r = '0;
        mag = fb[30:0];
        last = 0;
        sticky = 0;
        if (mag > f2d_pkg::MAG_LIMIT) begin
            r.status = 1'b1;
            return r;
        end
        if (mag == 0) return r;
        if (mag[30:23] == 0) begin
            m = {1'b0, mag[22:0]};
            e2 = -149;
        end else begin
            m = {1'b1, mag[22:0]};
            e2 = int'(mag[30:23]) - 150;
        end
        big = 384'(m);
        e = 0;
        if (e2 >= 0) big = big << e2;
        else begin
            for (int i = 0; i < -e2; i++) big = big * 384'd5;
            e = e2;
        end
        while (big >= 384'd10000000) begin
            if (last != 0) sticky = 1;
            last = 4'(big % 384'd10);
            big = big / 384'd10;
            e++;
        end
        q = 32'(big);
        while (q < 32'd1000000) begin
            q = q * 10;
            e--;
        end
        if (e + 6 < -28) begin
            r.status = 1'b1;
            return r;
        end
        if (last > 5 || (last == 5 && (sticky || q[0]))) q++;
        if (q == 32'd10000000) begin
            q = 32'd1000000;
            e++;
        end
        sc = -e;
        n96 = 96'(q);
        if (sc < 0) begin
            for (int i = 0; i < -sc; i++) begin
                wide = 100'(n96) * 100'd10;
                if (wide[99:96] != 0) begin
                    r.status = 1'b1;
                    return r;
                end
                n96 = wide[95:0];
            end
            sc = 0;
        end
        while (sc > MAX_SCALE) begin
            rem = 4'(n96 % 96'd10);
            n96 = n96 / 96'd10;
            if (rem > 5 || (rem == 5 && n96[0])) n96 = n96 + 1;
            sc--;
        end
        if (n96 == 0) return r;
        r.mant_lo = n96[63:0];
        r.mant_hi = n96[95:64];
        r.scale   = f2d_pkg::SCALE_W'(sc);
        r.neg     = fb[31];
        return r;
    endfunction

    task automatic send_float(logic [f2d_pkg::FW-1:0] fb, logic has_exp, t_dec_res exp_res);
        t_dec_res pred;
        while (($urandom_range(99, 0)) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        pred = convert_float(fb);
        if (has_exp && pred != exp_res) begin
            mismatches++;
            if (mismatches <= 10)
                $display("table row %h: typed %h predictor %h", fb, exp_res, pred);
        end
        in_ch.valid      <= 1'b1;
        in_ch.float_bits <= fb;
        pending_dec.push_back(pred);
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    // receiver: random stalls, sample beats at the edge
    always @(posedge i_clk) begin
        t_dec_res got, want;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                got = '{out_ch.mantissa_low, out_ch.mantissa_high, out_ch.scale,
                        out_ch.negative, out_ch.status};
                if (pending_dec.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected beat %h", got);
                end else begin
                    want = pending_dec.pop_front();
                    if (got != want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %h actual %h", want, got);
                    end
                end
            end
            out_ch.ready <= !hold_recv && ($urandom_range(99, 0) >= recv_idle_pct);
        end
    end

    // watchdog on beats in either direction
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
                || (stim_done && pending_dec.size() == 0))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WD_LIMIT) begin
            $display("float_to_decimal96_convert test failed");
            $finish;
        end
    end

    function automatic logic [f2d_pkg::FW-1:0] rand_float();
        logic [f2d_pkg::FW-1:0] v;
        v = $urandom();
        case ($urandom_range(5, 0))
            0: v[30:23] = 8'($urandom_range(103, 0));        // tiny and subnormal
            1: v[30:23] = 8'($urandom_range(255, 186));      // large, too large, inf, nan
            default: v[30:23] = 8'($urandom_range(190, 30)); // in range, near edges
        endcase
        return v;
    endfunction

    t_stim_row dir_rows[$];

    initial begin
        t_dec_res z, err;
        z = '0;
        err = '0;
        err.status = 1'b1;
        mismatches = 0;
        stim_done = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.float_bits = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        dir_rows = '{
            '{32'h0000_0000, 1'b1, z},                   // plus zero
            '{32'h8000_0000, 1'b1, z},                   // minus zero
            '{32'h7F80_0000, 1'b1, err},                 // infinity
            '{32'hFF80_0000, 1'b1, err},                 // minus infinity
            '{32'h7FC0_0000, 1'b1, err},                 // nan
            '{32'hFFFF_FFFF, 1'b1, err},                 // nan, all ones
            '{32'h0000_0001, 1'b1, err},                 // smallest subnormal
            '{32'h007F_FFFF, 1'b1, err},                 // largest subnormal
            '{32'h6F80_0001, 1'b1, err},                 // just above 2^96
            '{32'h6F80_0000, 1'b0, z},                   // exactly 2^96
            '{32'hEF80_0000, 1'b0, z},
            '{32'h3F80_0000, 1'b1, '{64'd1000000, 32'd0, 5'd6, 1'b0, 1'b0}}, // 1.0
            '{32'hBF80_0000, 1'b1, '{64'd1000000, 32'd0, 5'd6, 1'b1, 1'b0}}, // -1.0
            '{32'h3DCC_CCCD, 1'b0, z},                   // 0.1
            '{32'h4B7F_FFFF, 1'b0, z},                   // rounding carry
            '{32'h4B18_9680, 1'b0, z},                   // 10000000
            '{32'h4B18_9681, 1'b0, z},                   // tie region
            '{32'h1272_6DAE, 1'b0, z},                   // near 1e-28
            '{32'h1262_6DAE, 1'b0, z},
            '{32'h0080_0000, 1'b1, err},                 // smallest normal
            '{32'h7F7F_FFFF, 1'b1, err},                 // largest normal
            '{32'h4F00_0000, 1'b0, z},
            '{32'h5F80_0000, 1'b0, z}
        };
        foreach (dir_rows[i])
            send_float(dir_rows[i].bits, dir_rows[i].has_exp, dir_rows[i].exp_res);

        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 8 : (ph == 1) ? 57 : 0;
            recv_idle_pct = (ph == 0) ? 57 : (ph == 1) ? 8 : 0;
            for (int i = 0; i < 510; i++) begin
                // long receiver hold-off while input keeps coming
                if (ph == 2 && i == 100) begin
                    fork
                        begin
                            hold_recv <= 1'b1;
                            repeat (300) @(posedge i_clk);
                            hold_recv <= 1'b0;
                        end
                    join_none
                end
                send_float(rand_float(), 1'b0, z);
            end
        end
        in_ch.valid <= 1'b0;

        stim_done = 1;
        while (pending_dec.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("float_to_decimal96_convert test passed");
        end else begin
            $display("float_to_decimal96_convert test failed");
        end
        $finish;
    end
endmodule

// File: float_to_decimal96_convert.f
hdl/f2d_pkg.sv
hdl/f2d_if.sv
hdl/float_to_decimal96_convert.sv
dv/float_to_decimal96_convert_test.sv
